// ===== design/first_seen_id_renumbering_defines.svh =====
// Assertion macros shared by the renumbering block
`ifndef FIRST_SEEN_ID_RENUMBERING_DEFINES_SVH
`define FIRST_SEEN_ID_RENUMBERING_DEFINES_SVH

// Condition must hold at every clock edge out of reset
`define FSIR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define FSIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fsir_pkg.sv =====
// Types and constants for the first-seen identifier renumbering block
package fsir_pkg;

   localparam int ID_WIDTH = 24;

   typedef struct packed {
      logic [ID_WIDTH-1:0] node_id;
      logic                start_req;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [7:0] local_index;
      logic       was_new;
      logic [8:0] distinct_count;
      logic       overflow;
      logic       last_out;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // latch request beat, restart scan
      logic scan;    // search state active
      logic finish;  // write result register, insert on miss if not full
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;    // lookup resolved (hit or miss)
   } stat_type;

endpackage

// ===== design/fsir_dpath.sv =====
// Datapath: identifier table, scan pointer, compare stage and result register
`include "first_seen_id_renumbering_defines.svh"

module fsir_dpath #(
   parameter int TABLE_DEPTH = 256,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  fsir_pkg::cmd_type cmd,
   output fsir_pkg::stat_type stat,
   input  fsir_pkg::req_type req_data,
   output fsir_pkg::rsp_type rsp_data
);

   logic [fsir_pkg::ID_WIDTH-1:0] mem [TABLE_DEPTH];

   logic [fsir_pkg::ID_WIDTH-1:0] id_ff, id_in;
   logic                          last_ff, last_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              scan_ff, scan_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]              cmp_idx_ff, cmp_idx_in;
   logic [fsir_pkg::ID_WIDTH-1:0] rd_data_ff;
   fsir_pkg::rsp_type             rsp_ff, rsp_in;

   logic             full;
   logic             match;
   logic             miss;
   logic             done;
   logic             advance;
   logic             issue;
   logic             insert;
   logic [CNT_W-1:0] count_next;
   logic [IDX_W-1:0] index;

   always_comb begin
      full    = (count_ff == CNT_W'(TABLE_DEPTH));
      match   = cmp_vld_ff && (rd_data_ff == id_ff);
      miss    = !cmp_vld_ff && (scan_ff == count_ff);
      done    = match || miss;
      advance = cmd.scan && !done;
      issue   = advance && (scan_ff < count_ff);
      insert  = cmd.finish && !match && !full;
      stat.done = done;

      count_next = insert ? count_ff + 1'b1 : count_ff;
      if (match) begin
         index = cmp_idx_ff;
      end else if (full) begin
         index = '0;
      end else begin
         index = count_ff[IDX_W-1:0];
      end

      id_in      = id_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      rsp_in     = rsp_ff;

      if (cmd.load) begin
         id_in      = req_data.node_id;
         last_in    = req_data.last;
         scan_in    = '0;
         cmp_vld_in = 1'b0;
         if (req_data.start_req) begin
            count_in = '0;
         end
      end else if (advance) begin
         cmp_vld_in = issue;
         if (issue) begin
            scan_in    = scan_ff + 1'b1;
            cmp_idx_in = scan_ff[IDX_W-1:0];
         end
      end

      if (cmd.finish) begin
         count_in              = count_next;
         rsp_in.local_index    = 8'(index);
         rsp_in.was_new        = insert;
         rsp_in.distinct_count = 9'(count_next);
         rsp_in.overflow       = !match && full;
         rsp_in.last_out       = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         scan_ff    <= scan_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      id_ff      <= id_in;
      last_ff    <= last_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   // single-port table: one write on insert, one registered read per scan step
   always_ff @(posedge clock) begin
      if (insert) begin
         mem[count_ff[IDX_W-1:0]] <= id_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[scan_ff[IDX_W-1:0]];
      end
   end

   assign rsp_data = rsp_ff;

   `FSIR_ASSERT_ALWAYS(a_count_in_range, count_ff <= CNT_W'(TABLE_DEPTH),
      "stored count above table depth")
   `FSIR_ASSERT_ALWAYS(a_scan_bounded, scan_ff <= count_ff,
      "scan pointer ran past stored count")
   `FSIR_ASSERT_NEXT(a_insert_counts, insert, count_ff == $past(count_ff) + 1'b1,
      "insert did not bump stored count")

endmodule

// ===== design/fsir_ctrl.sv =====
// Controller: accept, search and result handoff sequencing
`include "first_seen_id_renumbering_defines.svh"

module fsir_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  fsir_pkg::stat_type stat,
   output fsir_pkg::cmd_type  cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (stat.done && slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FSIR_ASSERT_NEXT(a_stall_holds,
      state_ff == ST_SEARCH && stat.done && !slot_free,
      state_ff == ST_SEARCH && stat.done,
      "resolved lookup lost while result slot busy")

endmodule

// ===== design/first_seen_id_renumbering.sv =====
// Top level: first-seen identifier renumbering (dense index by first appearance)
//
//  channel | direction | handshake             | beat payload
//  --------+-----------+-----------------------+---------------------
//  req     | in        | req_valid / req_ready | fsir_pkg::req_type
//  rsp     | out       | rsp_valid / rsp_ready | fsir_pkg::rsp_type
//
// Flow: one beat at a time; the table is scanned one entry per cycle, registered read
//   then compare. The result register loads once the lookup hits or runs past the stored
//   entries (or finds an empty table) and the result slot is free; req_ready returns
//   together with rsp_valid, so no new beat is taken before the last one is through.
// Reset: synchronous, active high; clears stored count and control state, not the table.
// Stalls: a held rsp stalls only the finish of the next beat; start_req zeroes count first.

module first_seen_id_renumbering #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fsir_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fsir_pkg::rsp_type rsp_data
);

   fsir_pkg::cmd_type  cmd;
   fsir_pkg::stat_type stat;

   // sequencer: idle -> search -> idle, hands result to rsp register
   fsir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table memory, scan/compare pipeline, stored count, result register
   fsir_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== verif/first_seen_id_renumbering_checker.sv =====
// Checker for the renumbering block: predicts each result beat and compares it
`timescale 1ns / 1ps

module first_seen_id_renumbering_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  fsir_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  fsir_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                waiting,
   output int                checked
);

   // predictor state: identifiers in order of first appearance, and their count
   logic [fsir_pkg::ID_WIDTH-1:0] seen_table [TABLE_DEPTH];
   logic [8:0]                    seen_count;

   fsir_pkg::rsp_type expected_rsps[$];
   fsir_pkg::rsp_type want;

   // first-seen lookup; appends on a miss while there is room
   function automatic fsir_pkg::rsp_type renumber(input fsir_pkg::req_type beat);
      fsir_pkg::rsp_type r;
      bit                hit;
      int                k;
      r   = '0;
      hit = 1'b0;
      if (beat.start_req) seen_count = '0;
      for (k = 0; k < seen_count; k++) begin
         if (!hit && seen_table[k] == beat.node_id) begin
            hit           = 1'b1;
            r.local_index = 8'(k);
         end
      end
      if (!hit) begin
         if (seen_count < TABLE_DEPTH) begin
            seen_table[seen_count] = beat.node_id;
            r.local_index          = seen_count[7:0];
            r.was_new              = 1'b1;
            seen_count             = seen_count + 9'd1;
         end else begin
            r.overflow = 1'b1;
         end
      end
      r.distinct_count = seen_count;
      r.last_out       = beat.last;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         seen_count = '0;
         expected_rsps.delete();
         fail_count = 0;
         checked    = 0;
      end else begin
         // compare first: a result never belongs to a beat accepted this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat, got %h", $realtime, rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               checked++;
               if (rsp_data.local_index !== want.local_index ||
                   rsp_data.was_new !== want.was_new ||
                   rsp_data.distinct_count !== want.distinct_count ||
                   rsp_data.overflow !== want.overflow ||
                   rsp_data.last_out !== want.last_out) begin
                  fail_count++;
                  $display("%0t: mismatch expected idx %0d new %b cnt %0d ovf %b last %b",
                           $realtime, want.local_index, want.was_new,
                           want.distinct_count, want.overflow, want.last_out);
                  $display("%0t:          actual   idx %0d new %b cnt %0d ovf %b last %b",
                           $realtime, rsp_data.local_index, rsp_data.was_new,
                           rsp_data.distinct_count, rsp_data.overflow, rsp_data.last_out);
               end
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(renumber(req_data));
      end
      waiting = expected_rsps.size();
   end

endmodule

// ===== verif/first_seen_id_renumbering_tb.sv =====
// Testbench top for the renumbering block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module first_seen_id_renumbering_tb;

   localparam int TABLE_DEPTH    = 256;
   localparam int ID_W           = fsir_pkg::ID_WIDTH;
   // long receiver hold-off, counted in the receiver's own process
   localparam int HOLD_CYCLES    = 1200;
   // cycles with no beat on either channel before the run is abandoned;
   // a full-table miss scans every stored entry, the hold-off above takes far longer
   localparam int WATCHDOG_LIMIT = 10000;
   // drain time after the last result, a little over the slowest beat
   localparam int TAIL_CYCLES    = 300;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fsir_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fsir_pkg::rsp_type rsp_data;

   int fail_count;
   int waiting;
   int checked;

   // flow control knobs, percent of cycles
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int holds_asked    = 0;   // written by stimulus only
   int holds_done     = 0;   // written by receiver only
   int beats_sent     = 0;
   int quiet_cycles   = 0;
   int table_fills    = 0;

   first_seen_id_renumbering #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   first_seen_id_renumbering_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) renumber_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .fail_count(fail_count),
      .waiting   (waiting),
      .checked   (checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: random stalls at the falling edge; on request one long hold-off
   // so that the result register stays full and the block stops taking beats.
   always begin
      @(negedge clock);
      if (holds_done != holds_asked) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         holds_done++;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Watchdog: any accepted beat on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // One request beat: optional idle gap, then valid held until accepted.
   // Valid stays high into the next beat when no gap is drawn.
   task automatic send_id(input logic [ID_W-1:0] id, input bit start, input bit last);
      fsir_pkg::req_type beat;
      beat.node_id   = id;
      beat.start_req = start;
      beat.last      = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // Sender pause: drop valid and wait until every predicted result is back.
   // The falling edge comes first so the checker has seen the last accept.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (waiting == 0);
   endtask

   // Fill the table to the brim, then mix overflowing new ids with known ones.
   // Low byte is the slot number, so the 256 fill ids are distinct; the first
   // and the last are the all-zero and all-one identifiers.
   task automatic fill_table(input int extra);
      logic [ID_W-1:0] stored [TABLE_DEPTH];
      logic [ID_W-1:0] id;
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         if (i == 0) id = '0;
         else if (i == TABLE_DEPTH - 1) id = '1;
         else id = {16'($urandom), 8'(i)};
         stored[i] = id;
         send_id(id, i == 0, 1'b0);
      end
      for (i = 0; i < extra; i++) begin
         // table full: new ids overflow, known ids still hit
         if ($urandom_range(0, 1)) id = ID_W'($urandom);
         else id = stored[$urandom_range(0, TABLE_DEPTH - 1)];
         send_id(id, 1'b0, i == extra - 1);
      end
      table_fills++;
   endtask

   // Runs drawn from a small pool of random ids so hits dominate; a few runs
   // are broken: no start flag, stray start or last mid-run; any beat may be a fresh id.
   task automatic random_runs(input int count);
      logic [ID_W-1:0] pool [32];
      logic [ID_W-1:0] id;
      int  stop_at;
      int  run_len;
      int  pool_size;
      int  i;
      bit  broken;
      bit  start;
      bit  last;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         run_len   = $urandom_range(1, 40);
         pool_size = $urandom_range(1, 32);
         broken    = ($urandom_range(0, 9) == 0);
         for (i = 0; i < pool_size; i++) pool[i] = ID_W'($urandom);
         for (i = 0; i < run_len; i++) begin
            if ($urandom_range(0, 15) == 0) id = ID_W'($urandom);
            else id = pool[$urandom_range(0, pool_size - 1)];
            start = (i == 0) && !broken;
            last  = (i == run_len - 1);
            if (broken) begin
               start = ($urandom_range(0, 19) == 0);
               last  = last ^ ($urandom_range(0, 9) == 0);
            end
            send_id(id, start, last);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: id extremes, hit and miss, last not clearing the table,
      // a run carried on without start, start and last on one beat.
      send_id(24'h000000, 1'b1, 1'b0);   // new, index 0
      send_id(24'hFFFFFF, 1'b0, 1'b0);   // new, index 1
      send_id(24'h000000, 1'b0, 1'b0);   // hit 0
      send_id(24'hFFFFFF, 1'b0, 1'b1);   // hit 1, last echoed
      send_id(24'h123456, 1'b0, 1'b0);   // no start: table carries over
      send_id(24'h000000, 1'b0, 1'b0);   // still hit 0 after last
      send_id(24'hFFFFFF, 1'b1, 1'b0);   // start: index 0 again
      send_id(24'h000000, 1'b0, 1'b0);
      send_id(24'hAAAAAA, 1'b0, 1'b0);
      send_id(24'h555555, 1'b0, 1'b0);
      send_id(24'h555555, 1'b0, 1'b0);
      send_id(24'hAAAAAA, 1'b0, 1'b1);
      send_id(24'h555555, 1'b1, 1'b1);   // start and last together
      send_id(24'h555555, 1'b1, 1'b0);   // back-to-back start, same id
      send_id(24'h555555, 1'b0, 1'b0);
      send_id(24'h800000, 1'b0, 1'b0);
      send_id(24'h000001, 1'b0, 1'b0);
      send_id(24'h800000, 1'b0, 1'b1);
      drain();

      // Phase 1: no idling on either side, plus a full table
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fill_table(20);
      random_runs(180);
      drain();

      // Phase 2: sender mostly idle
      send_idle_pct = 86;
      rsp_stall_pct = 0;
      random_runs(190);
      drain();

      // Phase 3: receiver mostly stalled, second full table
      send_idle_pct = 0;
      rsp_stall_pct = 86;
      random_runs(100);
      fill_table(20);
      drain();

      // Phase 4: light idling on both sides; a long hold-off at the start
      // while the sender keeps offering beats, so req_ready drops
      send_idle_pct = 18;
      rsp_stall_pct = 18;
      holds_asked++;
      random_runs(200);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d request beats sent, %0d results checked over four flow-control phases,",
               beats_sent, checked);
      $display("%0d table-full runs with overflow, one long receiver hold-off", table_fills);
      if (waiting != 0) $display("%0t: %0d results never arrived", $realtime, waiting);
      if (fail_count == 0 && waiting == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/fsir_pkg.sv
design/fsir_dpath.sv
design/fsir_ctrl.sv
design/first_seen_id_renumbering.sv
verif/first_seen_id_renumbering_checker.sv
verif/first_seen_id_renumbering_tb.sv
